@@ rtl/agms_pkg.sv @@
// ----------------------------------------------------------------------------
// agms_pkg
// Shared types and constants for the adjacency-matrix graph store.
// ----------------------------------------------------------------------------
package agms_pkg;

   localparam int ID_W         = 32;
   localparam int COUNT_W      = 16;
   localparam int NODE_COUNT_W = 7;
   localparam int EDGE_COUNT_W = 13;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [COUNT_W-1:0]      COUNTER_MAX = '1;
   localparam logic [EDGE_COUNT_W-1:0] EDGE_MAX    = '1;

   typedef enum logic [1:0] {
      OP_INSERT_NODE,
      OP_INSERT_EDGE,
      OP_TEST_EDGE,
      OP_READ_COUNT
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DUPLICATE,
      ST_FULL,
      ST_NOT_FOUND
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_WRITE_DST
   } back_state_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] first_id;
      logic signed [31:0] second_id;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic                        connected;
      logic [COUNT_W-1:0]          connection_count;
      logic [NODE_COUNT_W-1:0]     node_count;
      logic [EDGE_COUNT_W-1:0]     edge_count;
   } rsp_type;

endpackage

@@ rtl/agms_front.sv @@
// ----------------------------------------------------------------------------
// agms_front
// Id table and lookup: matches both ids against the filled slots in parallel,
// inserts new nodes and classifies each item into a command for the back end.
// ----------------------------------------------------------------------------
module agms_front #(
   parameter int  NODES  = 64,
   localparam int SLOT_W = $clog2(NODES),
   localparam int CNT_W  = $clog2(NODES + 1),
   localparam int CMD_W  = 4 + 2 * SLOT_W + agms_pkg::NODE_COUNT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  agms_pkg::req_type req_data,
   output logic [CMD_W-1:0]  cmd
);

   typedef struct packed {
      agms_pkg::op_type                   op;
      agms_pkg::status_type               status;
      logic [SLOT_W-1:0]                  slot_a;
      logic [SLOT_W-1:0]                  slot_b;
      logic [agms_pkg::NODE_COUNT_W-1:0]  node_count;
   } cmd_type;

   logic [agms_pkg::ID_W-1:0] id_table_ff [NODES];
   logic [CNT_W-1:0]          filled_ff;
   logic [CNT_W-1:0]          filled_in;
   logic [NODES-1:0]          match_a;
   logic [NODES-1:0]          match_b;
   logic [SLOT_W-1:0]         slot_a;
   logic [SLOT_W-1:0]         slot_b;
   logic                      table_we;
   cmd_type                   cmd_in;

   // ids are unique in the table, so at most one slot matches each id
   always_comb begin
      match_a = '0;
      match_b = '0;
      slot_a  = '0;
      slot_b  = '0;
      for (int i = 0; i < NODES; i++) begin
         if (filled_ff > CNT_W'(i)) begin
            match_a[i] = (id_table_ff[i] == $unsigned(req_data.first_id));
            match_b[i] = (id_table_ff[i] == $unsigned(req_data.second_id));
         end
         if (match_a[i]) begin
            slot_a = slot_a | SLOT_W'(i);
         end
         if (match_b[i]) begin
            slot_b = slot_b | SLOT_W'(i);
         end
      end
   end

   always_comb begin
      filled_in     = filled_ff;
      table_we      = 1'b0;
      cmd_in.op     = req_data.operation;
      cmd_in.status = agms_pkg::ST_OK;
      cmd_in.slot_a = slot_a;
      cmd_in.slot_b = slot_b;
      case (req_data.operation)
         agms_pkg::OP_INSERT_NODE: begin
            if (|match_a) begin
               cmd_in.status = agms_pkg::ST_DUPLICATE;
            end else if (filled_ff == CNT_W'(NODES)) begin
               cmd_in.status = agms_pkg::ST_FULL;
            end else begin
               table_we      = 1'b1;
               filled_in     = filled_ff + CNT_W'(1);
               cmd_in.slot_a = filled_ff[SLOT_W-1:0];
            end
         end
         agms_pkg::OP_INSERT_EDGE,
         agms_pkg::OP_TEST_EDGE: begin
            if (!(|match_a) || !(|match_b)) begin
               cmd_in.status = agms_pkg::ST_NOT_FOUND;
            end
         end
         agms_pkg::OP_READ_COUNT: begin
            if (!(|match_a)) begin
               cmd_in.status = agms_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            cmd_in.status = agms_pkg::ST_NOT_FOUND;
         end
      endcase
      cmd_in.node_count = agms_pkg::NODE_COUNT_W'(filled_in);
   end

   assign cmd = cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (accept) begin
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && table_we) begin
         id_table_ff[filled_ff[SLOT_W-1:0]] <= $unsigned(req_data.first_id);
      end
   end

endmodule

@@ rtl/agms_fifo.sv @@
// ----------------------------------------------------------------------------
// agms_fifo
// Short command queue between the lookup front end and the matrix back end.
// ----------------------------------------------------------------------------
module agms_fifo #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

endmodule

@@ rtl/agms_back.sv @@
// ----------------------------------------------------------------------------
// agms_back
// Executes classified commands: edge matrix row read-modify-write, per-node
// saturating counters, distinct edge count and the registered result.
// ----------------------------------------------------------------------------
module agms_back #(
   parameter int  NODES  = 64,
   localparam int SLOT_W = $clog2(NODES),
   localparam int CMD_W  = 4 + 2 * SLOT_W + agms_pkg::NODE_COUNT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  logic [CMD_W-1:0]  head,
   output logic              pop,
   output logic              rsp_valid,
   output agms_pkg::rsp_type rsp_data
);

   typedef struct packed {
      agms_pkg::op_type                   op;
      agms_pkg::status_type               status;
      logic [SLOT_W-1:0]                  slot_a;
      logic [SLOT_W-1:0]                  slot_b;
      logic [agms_pkg::NODE_COUNT_W-1:0]  node_count;
   } cmd_type;

   cmd_type                            head_cmd;
   cmd_type                            cmd_ff;
   agms_pkg::back_state_type           state_ff;
   agms_pkg::back_state_type           state_in;

   logic [NODES-1:0]                   row_mem [NODES];
   logic [agms_pkg::COUNT_W-1:0]       cnt_mem [NODES];
   logic [NODES-1:0]                   row_rd_ff;
   logic [agms_pkg::COUNT_W-1:0]       cnt_a_rd_ff;
   logic [agms_pkg::COUNT_W-1:0]       cnt_b_rd_ff;

   logic                               row_we;
   logic [NODES-1:0]                   row_wdata;
   logic                               cnt_we;
   logic [SLOT_W-1:0]                  cnt_waddr;
   logic [agms_pkg::COUNT_W-1:0]       cnt_wdata;
   logic [agms_pkg::COUNT_W-1:0]       new_a;

   logic [agms_pkg::COUNT_W-1:0]       cnt_b_new_ff;
   logic [agms_pkg::COUNT_W-1:0]       cnt_b_new_in;
   logic [agms_pkg::EDGE_COUNT_W-1:0]  edge_cnt_ff;
   logic [agms_pkg::EDGE_COUNT_W-1:0]  edge_cnt_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   agms_pkg::rsp_type                  rsp_ff;
   agms_pkg::rsp_type                  rsp_in;

   assign head_cmd = head;

   always_comb begin
      new_a = (cnt_a_rd_ff == agms_pkg::COUNTER_MAX) ? agms_pkg::COUNTER_MAX
                                                      : cnt_a_rd_ff + agms_pkg::COUNT_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      row_we        = 1'b0;
      row_wdata     = row_rd_ff | (NODES'(1) << cmd_ff.slot_b);
      cnt_we        = 1'b0;
      cnt_waddr     = cmd_ff.slot_a;
      cnt_wdata     = new_a;
      cnt_b_new_in  = cnt_b_new_ff;
      edge_cnt_in   = edge_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_in.status           = cmd_ff.status;
      rsp_in.connected        = 1'b0;
      rsp_in.connection_count = '0;
      rsp_in.node_count       = cmd_ff.node_count;
      case (state_ff)
         agms_pkg::BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = agms_pkg::BK_EXEC;
            end
         end
         agms_pkg::BK_EXEC: begin
            state_in     = agms_pkg::BK_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff.status == agms_pkg::ST_OK) begin
               case (cmd_ff.op)
                  agms_pkg::OP_INSERT_NODE: begin
                     // fresh slot: clear its row and counter
                     row_we    = 1'b1;
                     row_wdata = '0;
                     cnt_we    = 1'b1;
                     cnt_wdata = '0;
                  end
                  agms_pkg::OP_INSERT_EDGE: begin
                     row_we = 1'b1;
                     cnt_we = 1'b1;
                     if (!row_rd_ff[cmd_ff.slot_b] && (edge_cnt_ff != agms_pkg::EDGE_MAX)) begin
                        edge_cnt_in = edge_cnt_ff + agms_pkg::EDGE_COUNT_W'(1);
                     end
                     // self edge: destination bump stacks on the source bump
                     if (cmd_ff.slot_a == cmd_ff.slot_b) begin
                        cnt_b_new_in = (new_a == agms_pkg::COUNTER_MAX) ? agms_pkg::COUNTER_MAX
                                       : new_a + agms_pkg::COUNT_W'(1);
                     end else begin
                        cnt_b_new_in = (cnt_b_rd_ff == agms_pkg::COUNTER_MAX)
                                       ? agms_pkg::COUNTER_MAX
                                       : cnt_b_rd_ff + agms_pkg::COUNT_W'(1);
                     end
                     rsp_valid_in = 1'b0;
                     state_in     = agms_pkg::BK_WRITE_DST;
                  end
                  agms_pkg::OP_TEST_EDGE: begin
                     rsp_in.connected = row_rd_ff[cmd_ff.slot_b];
                  end
                  agms_pkg::OP_READ_COUNT: begin
                     rsp_in.connection_count = cnt_a_rd_ff;
                  end
                  default: begin
                     rsp_in.connected = 1'b0;
                  end
               endcase
            end
         end
         agms_pkg::BK_WRITE_DST: begin
            cnt_we       = 1'b1;
            cnt_waddr    = cmd_ff.slot_b;
            cnt_wdata    = cnt_b_new_ff;
            rsp_valid_in = 1'b1;
            state_in     = agms_pkg::BK_IDLE;
         end
         default: begin
            state_in = agms_pkg::BK_IDLE;
         end
      endcase
      rsp_in.edge_count = edge_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agms_pkg::BK_IDLE;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_cnt_ff  <= edge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
      cnt_b_new_ff <= cnt_b_new_in;
      rsp_ff       <= rsp_in;
   end

   // matrix rows: one read at pop, one write during execution
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[cmd_ff.slot_a] <= row_wdata;
      end
      if (pop) begin
         row_rd_ff <= row_mem[head_cmd.slot_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (pop) begin
         cnt_a_rd_ff <= cnt_mem[head_cmd.slot_a];
         cnt_b_rd_ff <= cnt_mem[head_cmd.slot_b];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/adjacency_matrix_graph_store.sv @@
// An accepted item is queued, popped by the idle back end with its row and counter
// reads, then executed, and its result strobe is registered; an edge insert adds
// the BK_WRITE_DST state for the destination counter write. The front end keeps
// accepting while the queue has room; the back end finishes one item before the next pop.
// Results cannot be stalled; busy rises only while the 2-entry queue is full.
// Reset clears the node and edge counts; no clearing pass, accepts at once.
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Directed graph store: id table lookup front end, command queue, and a back
// end holding the edge bit matrix and per-node connection counters.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store #(
   parameter int NODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  agms_pkg::req_type req_data,
   output logic              rsp_valid,
   output agms_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(NODES);
   localparam int CMD_W  = 4 + 2 * SLOT_W + agms_pkg::NODE_COUNT_W;

   logic             accept;
   logic [CMD_W-1:0] front_cmd;
   logic [CMD_W-1:0] queue_head;
   logic             fifo_pop;
   logic             fifo_empty;
   logic             fifo_full;

   assign busy   = fifo_full;
   assign accept = start && !busy;

   agms_front #(
      .NODES (NODES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   agms_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (agms_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .pop       (fifo_pop),
      .head      (queue_head),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   agms_back #(
      .NODES (NODES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (fifo_empty),
      .head      (queue_head),
      .pop       (fifo_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_empty)
      else $error("queue popped while empty");

   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on back-to-back cycles");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != agms_pkg::ST_OK))
         |-> (!rsp_data.connected && (rsp_data.connection_count == '0)))
      else $error("error result carries data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == agms_pkg::ST_FULL))
         |-> (rsp_data.node_count == agms_pkg::NODE_COUNT_W'(NODES)))
      else $error("table full reported below capacity");

endmodule

@@ dv/adjacency_matrix_graph_store_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_test
// Drives node inserts, edge inserts, connection tests and counter reads into
// the graph store. A scoreboard keeps its own copy of the id table, edge
// matrix and counters and checks every result field against it.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_test;

   localparam int          GRAPH_NODES = 64;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam logic [31:0] ID_MIN      = 32'h8000_0000;
   localparam logic [31:0] ID_MAX      = 32'h7FFF_FFFF;

   class graph_scoreboard;
      logic [31:0]                      ids [GRAPH_NODES];
      logic [GRAPH_NODES-1:0]           edges [GRAPH_NODES];
      logic [agms_pkg::COUNT_W-1:0]     links [GRAPH_NODES];
      int unsigned                      filled;
      logic [agms_pkg::EDGE_COUNT_W-1:0] edge_total;
      agms_pkg::rsp_type                pending_rsp [$];
      int unsigned                      errors;

      function new();
         filled = 0;
         edge_total = '0;
         errors = 0;
         foreach (edges[i]) edges[i] = '0;
      endfunction

      // only filled slots are searched
      function int slot_of(logic [31:0] id);
         for (int i = 0; i < filled; i++) begin
            if (ids[i] == id) return i;
         end
         return -1;
      endfunction

      function void note_request(agms_pkg::req_type item);
         agms_pkg::rsp_type want;
         int                a;
         int                b;
         want = '0;
         want.status = agms_pkg::ST_OK;
         a = slot_of(item.first_id);
         b = slot_of(item.second_id);
         case (item.operation)
            agms_pkg::OP_INSERT_NODE: begin
               if (a >= 0) begin
                  want.status = agms_pkg::ST_DUPLICATE;
               end else if (filled >= GRAPH_NODES) begin
                  want.status = agms_pkg::ST_FULL;
               end else begin
                  ids[filled] = item.first_id;
                  links[filled] = '0;
                  filled++;
               end
            end
            agms_pkg::OP_INSERT_EDGE: begin
               if (a < 0 || b < 0) begin
                  want.status = agms_pkg::ST_NOT_FOUND;
               end else begin
                  // self edge bumps the same counter twice
                  if (links[a] != agms_pkg::COUNTER_MAX) links[a]++;
                  if (links[b] != agms_pkg::COUNTER_MAX) links[b]++;
                  if (!edges[a][b]) begin
                     edges[a][b] = 1'b1;
                     if (edge_total != agms_pkg::EDGE_MAX) edge_total++;
                  end
               end
            end
            agms_pkg::OP_TEST_EDGE: begin
               if (a < 0 || b < 0) want.status = agms_pkg::ST_NOT_FOUND;
               else want.connected = edges[a][b];
            end
            default: begin
               if (a < 0) want.status = agms_pkg::ST_NOT_FOUND;
               else want.connection_count = links[a];
            end
         endcase
         want.node_count = agms_pkg::NODE_COUNT_W'(filled);
         want.edge_count = edge_total;
         pending_rsp.push_back(want);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            errors++;
         end
      endfunction

      function void check_response(agms_pkg::rsp_type seen);
         agms_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %p", $time, seen);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("status", want.status, seen.status);
         compare_field("connected", want.connected, seen.connected);
         compare_field("connection_count", want.connection_count, seen.connection_count);
         compare_field("node_count", want.node_count, seen.node_count);
         compare_field("edge_count", want.edge_count, seen.edge_count);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   agms_pkg::req_type req_data;
   logic              rsp_valid;
   agms_pkg::rsp_type rsp_data;

   graph_scoreboard sb = new();
   int unsigned     cycles = 0;
   logic [31:0]     edge_src [$];
   logic [31:0]     edge_dst [$];

   adjacency_matrix_graph_store #(.NODES(GRAPH_NODES)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("adjacency_matrix_graph_store_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   function automatic agms_pkg::req_type make_req(agms_pkg::op_type op, logic [31:0] a,
                                                  logic [31:0] b);
      agms_pkg::req_type item;
      item.operation = op;
      item.first_id = a;
      item.second_id = b;
      return item;
   endfunction

   // mostly stored ids, some with one bit flipped, some fresh
   function automatic logic [31:0] pick_id();
      int unsigned roll;
      int unsigned k;
      logic [31:0] id;
      roll = $urandom_range(0, 99);
      if (sb.filled == 0 || roll < 10) begin
         id = $urandom;
      end else begin
         id = sb.ids[$urandom_range(0, sb.filled - 1)];
         if (roll < 18) begin
            k = $urandom_range(0, 31);
            id[k] = ~id[k];
         end
      end
      return id;
   endfunction

   function automatic agms_pkg::req_type random_item();
      agms_pkg::req_type item;
      int unsigned       roll;
      int unsigned       k;
      roll = $urandom_range(0, 99);
      item = make_req(agms_pkg::OP_TEST_EDGE, pick_id(), pick_id());
      if (roll < 20) begin
         item.operation = agms_pkg::OP_INSERT_NODE;
         if ($urandom_range(0, 3) != 0) item.first_id = $urandom;
         item.second_id = $urandom;
      end else if (roll < 55) begin
         item.operation = agms_pkg::OP_INSERT_EDGE;
         edge_src.push_back(item.first_id);
         edge_dst.push_back(item.second_id);
         if (edge_src.size() > 256) begin
            void'(edge_src.pop_front());
            void'(edge_dst.pop_front());
         end
      end else if (roll < 85) begin
         // bias some tests onto edges already inserted so hits are common
         if (edge_src.size() != 0 && $urandom_range(0, 9) < 4) begin
            k = $urandom_range(0, edge_src.size() - 1);
            item.first_id = edge_src[k];
            item.second_id = edge_dst[k];
         end
      end else begin
         item.operation = agms_pkg::OP_READ_COUNT;
         item.second_id = $urandom;
      end
      return item;
   endfunction

   task automatic send_item(input agms_pkg::req_type item);
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic idle_for(input int unsigned n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic run_random(input int unsigned count, input bit allow_idle);
      bit idling;
      idling = 1'b0;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 100 == 0) idling = allow_idle && ($urandom_range(0, 9) < 7);
         send_item(random_item());
         if (idling && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 14));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: the first lookups miss, then nodes and edges are inserted and tested
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MIN, 32'h0));
      send_item(make_req(agms_pkg::OP_TEST_EDGE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_INSERT_NODE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_INSERT_NODE, ID_MAX, ID_MIN));
      send_item(make_req(agms_pkg::OP_INSERT_NODE, 32'h0, 32'hFFFF_FFFF));
      send_item(make_req(agms_pkg::OP_INSERT_NODE, 32'hFFFF_FFFF, 32'h0));
      send_item(make_req(agms_pkg::OP_INSERT_NODE, ID_MAX, 32'h0));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MIN, ID_MAX));
      // repeated edge counts but leaves edge_count alone
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MAX, ID_MAX));
      send_item(make_req(agms_pkg::OP_TEST_EDGE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_TEST_EDGE, ID_MAX, ID_MIN));
      send_item(make_req(agms_pkg::OP_TEST_EDGE, ID_MAX, ID_MAX));
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MIN, 32'h0));
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MAX, 32'h0));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, 32'h0, 32'h1));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, 32'h1, 32'h0));
      send_item(make_req(agms_pkg::OP_TEST_EDGE, 32'h0, 32'hFFFF_FFFE));
      send_item(make_req(agms_pkg::OP_READ_COUNT, 32'h7FFF_FFFE, 32'h0));
      send_item(make_req(agms_pkg::OP_READ_COUNT, 32'h0, 32'hFFFF_FFFF));

      // table fills along the way, so later inserts hit the full case
      run_random(1700, 1'b1);

      // a short run of back-to-back self edges on one node
      repeat (20) send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MIN, ID_MIN));
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MIN, 32'h0));
      send_item(make_req(agms_pkg::OP_INSERT_EDGE, ID_MIN, ID_MAX));
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MIN, 32'h0));
      send_item(make_req(agms_pkg::OP_READ_COUNT, ID_MAX, 32'h0));

      run_random(300, 1'b0);

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("adjacency_matrix_graph_store_test: PASS");
      end else begin
         $display("adjacency_matrix_graph_store_test: FAIL");
      end
      $finish;
   end

endmodule
